/* hw/rtl/lrd_pkg.sv */
// Shared types, constants and the Adler-32 step for the log record deframer.
package lrd_pkg;

  localparam logic [16:0] AdlerMod    = 17'd65521;
  localparam logic [7:0]  EndMark     = 8'h42;
  localparam logic [31:0] MaxFieldLen = 32'd65535;

  typedef enum logic [2:0] {
    PhCsum = 3'd0,
    PhHlen = 3'd1,
    PhHdr  = 3'd2,
    PhLlen = 3'd3,
    PhLog  = 3'd4,
    PhType = 3'd5,
    PhEnd  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KindHeader = 2'd0,
    KindLog    = 2'd1,
    KindReport = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StMismatch = 2'd1,
    StBadEnd   = 2'd2,
    StRange    = 2'd3
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         payload_byte;
    status_e            status;
    logic [15:0]        header_length;
    logic [15:0]        log_length;
    logic signed [31:0] record_type;
    logic [31:0]        checksum_read;
    logic [31:0]        checksum_calc;
  } res_t;

  // core to top: result valid flag and error stop status
  typedef struct packed {
    logic res_valid;
    logic stopped;
  } core_stat_t;

  // One Adler-32 byte step; returns {high, low}.
  function automatic logic [31:0] adler_step(logic [15:0] lo, logic [15:0] hi,
                                             logic [7:0] b);
    logic [16:0] lo_sum;
    logic [16:0] hi_sum;
    lo_sum = {1'b0, lo} + {9'd0, b};
    if (lo_sum >= AdlerMod) begin
      lo_sum = lo_sum - AdlerMod;
    end
    hi_sum = {1'b0, hi} + lo_sum;
    if (hi_sum >= AdlerMod) begin
      hi_sum = hi_sum - AdlerMod;
    end
    return {hi_sum[15:0], lo_sum[15:0]};
  endfunction

endpackage

/* hw/rtl/lrd_if.sv */
// Valid/ready channel interfaces for the deframer byte input and result output.
interface lrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source(output valid, output data_byte, input ready);
  modport sink(input valid, input data_byte, output ready);
endinterface

interface lrd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         payload_byte;
  logic [1:0]         status;
  logic [15:0]        header_length;
  logic [15:0]        log_length;
  logic signed [31:0] record_type;
  logic [31:0]        checksum_read;
  logic [31:0]        checksum_calc;
  modport source(output valid, output kind, output payload_byte, output status,
                 output header_length, output log_length, output record_type,
                 output checksum_read, output checksum_calc, input ready);
  modport sink(input valid, input kind, input payload_byte, input status,
               input header_length, input log_length, input record_type,
               input checksum_read, input checksum_calc, output ready);
endinterface

/* hw/rtl/lrd_core.sv */
// Record parser state machine with Adler-32 accumulation, one byte per cycle while fire_i is high.
module lrd_core #(
  parameter logic [31:0] MaxFieldLen = lrd_pkg::MaxFieldLen
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          data_byte_i,
  output lrd_pkg::core_stat_t stat_o,
  output lrd_pkg::res_t       res_o
);

  lrd_pkg::phase_e phase_q, phase_d;
  logic [15:0] byte_count_q, byte_count_d;
  logic [31:0] word_shift_q, word_shift_d;
  logic [15:0] header_len_q, header_len_d;
  logic [15:0] log_len_q, log_len_d;
  logic [15:0] sum_low_q, sum_low_d;
  logic [15:0] sum_high_q, sum_high_d;
  logic [31:0] stored_q, stored_d;
  logic [31:0] type_q, type_d;
  logic        stopped_q, stopped_d;

  logic [31:0] calc;
  logic [31:0] adler_nx;
  logic [31:0] ws_new;
  logic [15:0] cnt_inc;
  logic [15:0] sec_len;
  lrd_pkg::res_t rpt;
  logic        res_valid;

  assign calc     = {sum_high_q, sum_low_q};
  assign adler_nx = lrd_pkg::adler_step(sum_low_q, sum_high_q, data_byte_i);
  assign ws_new   = {data_byte_i, word_shift_q[31:8]};
  assign cnt_inc  = byte_count_q + 16'd1;
  assign sec_len  = (phase_q == lrd_pkg::PhHdr) ? header_len_q : log_len_q;

  always_comb begin
    rpt               = '0;
    rpt.kind          = lrd_pkg::KindReport;
    rpt.status        = lrd_pkg::StOk;
    rpt.header_length = header_len_q;
    rpt.log_length    = log_len_q;
    rpt.record_type   = type_q;
    rpt.checksum_read = stored_q;
    rpt.checksum_calc = calc;
  end

  always_comb begin
    phase_d      = phase_q;
    byte_count_d = byte_count_q;
    word_shift_d = word_shift_q;
    header_len_d = header_len_q;
    log_len_d    = log_len_q;
    sum_low_d    = sum_low_q;
    sum_high_d   = sum_high_q;
    stored_d     = stored_q;
    type_d       = type_q;
    stopped_d    = stopped_q;
    res_valid    = 1'b0;
    res_o        = '0;
    if (fire_i && !stopped_q) begin
      unique case (phase_q)
        lrd_pkg::PhHdr, lrd_pkg::PhLog: begin
          sum_high_d         = adler_nx[31:16];
          sum_low_d          = adler_nx[15:0];
          byte_count_d       = cnt_inc;
          res_valid          = 1'b1;
          res_o.kind         = (phase_q == lrd_pkg::PhHdr) ? lrd_pkg::KindHeader
                                                            : lrd_pkg::KindLog;
          res_o.payload_byte = data_byte_i;
          if (cnt_inc >= sec_len) begin
            byte_count_d = '0;
            phase_d = (phase_q == lrd_pkg::PhHdr) ? lrd_pkg::PhLlen : lrd_pkg::PhType;
          end
        end
        lrd_pkg::PhEnd: begin
          res_valid = 1'b1;
          res_o     = rpt;
          if (data_byte_i != lrd_pkg::EndMark) begin
            stopped_d    = 1'b1;
            res_o.status = lrd_pkg::StBadEnd;
          end else begin
            phase_d      = lrd_pkg::PhCsum;
            byte_count_d = '0;
            word_shift_d = '0;
            header_len_d = '0;
            log_len_d    = '0;
            sum_low_d    = 16'd1;
            sum_high_d   = '0;
            stored_d     = '0;
            type_d       = '0;
          end
        end
        lrd_pkg::PhCsum, lrd_pkg::PhHlen, lrd_pkg::PhLlen, lrd_pkg::PhType: begin
          if (phase_q == lrd_pkg::PhType && byte_count_q == '0 && calc != stored_q) begin
            stopped_d    = 1'b1;
            res_valid    = 1'b1;
            res_o        = rpt;
            res_o.status = lrd_pkg::StMismatch;
          end else if (cnt_inc < 16'd4) begin
            word_shift_d = ws_new;
            byte_count_d = cnt_inc;
          end else begin
            word_shift_d = '0;
            byte_count_d = '0;
            unique case (phase_q)
              lrd_pkg::PhCsum: begin
                stored_d = ws_new;
                phase_d  = lrd_pkg::PhHlen;
              end
              lrd_pkg::PhHlen: begin
                header_len_d = ws_new[15:0];
                if (ws_new > MaxFieldLen) begin
                  stopped_d           = 1'b1;
                  res_valid           = 1'b1;
                  res_o               = rpt;
                  res_o.header_length = ws_new[15:0];
                  res_o.status        = lrd_pkg::StRange;
                end else begin
                  phase_d = (ws_new == '0) ? lrd_pkg::PhLlen : lrd_pkg::PhHdr;
                end
              end
              lrd_pkg::PhLlen: begin
                log_len_d = ws_new[15:0];
                if (ws_new > MaxFieldLen) begin
                  stopped_d        = 1'b1;
                  res_valid        = 1'b1;
                  res_o            = rpt;
                  res_o.log_length = ws_new[15:0];
                  res_o.status     = lrd_pkg::StRange;
                end else begin
                  phase_d = (ws_new == '0) ? lrd_pkg::PhType : lrd_pkg::PhLog;
                end
              end
              default: begin
                type_d  = ws_new;
                phase_d = lrd_pkg::PhEnd;
              end
            endcase
          end
        end
        default: begin
          phase_d      = lrd_pkg::PhCsum;
          byte_count_d = '0;
        end
      endcase
    end
  end

  always_comb begin
    stat_o.res_valid = res_valid;
    stat_o.stopped   = stopped_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= lrd_pkg::PhCsum;
      byte_count_q <= '0;
      word_shift_q <= '0;
      header_len_q <= '0;
      log_len_q    <= '0;
      sum_low_q    <= 16'd1;
      sum_high_q   <= '0;
      stored_q     <= '0;
      type_q       <= '0;
      stopped_q    <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      byte_count_q <= byte_count_d;
      word_shift_q <= word_shift_d;
      header_len_q <= header_len_d;
      log_len_q    <= log_len_d;
      sum_low_q    <= sum_low_d;
      sum_high_q   <= sum_high_d;
      stored_q     <= stored_d;
      type_q       <= type_d;
      stopped_q    <= stopped_d;
    end
  end

endmodule

/* hw/rtl/lrd_out_fifo.sv */
// Two-entry result buffer that decouples the core from output stalls.
module lrd_out_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lrd_pkg::res_t data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          ready_i,
  output lrd_pkg::res_t data_o
);

  lrd_pkg::res_t mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

endmodule

/* hw/rtl/log_record_deframer_adler32_unit.sv */
// Top level of the Adler-32 checked log record deframer.
// Usage:
//   in_i  : one stream byte per word (data_byte), valid/ready handshake.
//   out_o : zero or one result word per input byte: header byte, log byte,
//           or a report (end of record or error stop) with status, lengths,
//           record type, stored and computed checksum.
// Path: an accepted byte is held in the input register, parsed combinationally
//   when the output buffer has room, and its result is written into the
//   two-entry output buffer, which drives out_o.
// Throughput: one byte per cycle while the output buffer has room; the parse and
//   Adler update between the input register and the output buffer are combinational.
// in_i.ready depends only on registers; it drops when the input register is
//   held because the output buffer is full.
// Reset: the parser returns to expecting a checksum word, sums restart at
//   Adler-32 initial values, the error stop is cleared and both buffers empty.
// Receiver stall: results wait in the output buffer; once it is full the
//   input register holds and input is back-pressured. Nothing is dropped.
// After any error report the block swallows every byte until reset.
module log_record_deframer_adler32_unit #(
  parameter logic [31:0] MaxFieldLen = lrd_pkg::MaxFieldLen
) (
  input  logic clk_i,
  input  logic rst_ni,
  lrd_in_if.sink    in_i,
  lrd_out_if.source out_o
);

  logic       s0_valid_q;
  logic [7:0] s0_byte_q;
  logic       s0_fire;
  logic       fifo_full;
  lrd_pkg::core_stat_t core_stat;
  lrd_pkg::res_t       core_res;
  lrd_pkg::res_t       out_res;

  assign s0_fire    = s0_valid_q && !fifo_full;
  assign in_i.ready = !s0_valid_q || s0_fire;

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s0_byte_q <= in_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s0_valid_q <= in_i.valid;
    end
  end

  lrd_core #(
    .MaxFieldLen (MaxFieldLen)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (s0_fire),
    .data_byte_i (s0_byte_q),
    .stat_o      (core_stat),
    .res_o       (core_res)
  );

  lrd_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (core_stat.res_valid),
    .data_i  (core_res),
    .full_o  (fifo_full),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (out_res)
  );

  assign out_o.kind          = out_res.kind;
  assign out_o.payload_byte  = out_res.payload_byte;
  assign out_o.status        = out_res.status;
  assign out_o.header_length = out_res.header_length;
  assign out_o.log_length    = out_res.log_length;
  assign out_o.record_type   = out_res.record_type;
  assign out_o.checksum_read = out_res.checksum_read;
  assign out_o.checksum_calc = out_res.checksum_calc;

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_stat.res_valid |-> !fifo_full)
    else $error("result pushed into a full output buffer");

  a_stopped_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_stat.stopped |-> !core_stat.res_valid)
    else $error("result produced after an error stop");

  a_error_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (core_stat.res_valid && core_res.kind == lrd_pkg::KindReport &&
     core_res.status != lrd_pkg::StOk) |=> core_stat.stopped)
    else $error("error report did not stop the parser");

  a_byte_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (core_stat.res_valid && core_res.kind != lrd_pkg::KindReport) |->
    (core_res.status == lrd_pkg::StOk && core_res.checksum_calc == '0))
    else $error("byte result carries report fields");

endmodule

/* test/log_record_deframer_adler32_unit_tb.sv */
// Scoreboard testbench for the log record deframer: record streams in, checked results out.
module log_record_deframer_adler32_unit_tb;

  localparam int IdleLimit  = 4000;
  localparam int HoldCycles = 80;

  typedef enum int {FlawNone, FlawSum, FlawEnd, FlawHlen, FlawLlen} flaw_e;
  typedef enum int {FillOnes, FillZeros, FillRandom} fill_e;

  logic clk_i;
  logic rst_ni;

  lrd_in_if  in_ch();
  lrd_out_if out_ch();

  log_record_deframer_adler32_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  logic [7:0]    stream_q[$];
  lrd_pkg::res_t pending_results[$];
  int            total_n   = 0;
  int            taken_n   = 0;
  int            err_n     = 0;
  int            idle_n    = 0;
  int            hold_left = HoldCycles;
  logic          in_fire   = 1'b0;

  // deframer state as seen by the predictor
  lrd_pkg::phase_e ph;
  logic [15:0] cnt;
  logic [15:0] hlen_r;
  logic [15:0] llen_r;
  logic [31:0] shreg;
  logic [31:0] sums;
  logic [31:0] csum_r;
  logic [31:0] type_r;
  bit          halted;

  // sums packed as {high, low}
  function automatic logic [31:0] adler_next(input logic [31:0] acc, input logic [7:0] b);
    logic [16:0] lo;
    logic [16:0] hi;
    lo = {1'b0, acc[15:0]} + {9'd0, b};
    if (lo >= lrd_pkg::AdlerMod) begin
      lo = lo - lrd_pkg::AdlerMod;
    end
    hi = {1'b0, acc[31:16]} + lo;
    if (hi >= lrd_pkg::AdlerMod) begin
      hi = hi - lrd_pkg::AdlerMod;
    end
    return {hi[15:0], lo[15:0]};
  endfunction

  function automatic void clear_record();
    ph     = lrd_pkg::PhCsum;
    cnt    = '0;
    shreg  = '0;
    hlen_r = '0;
    llen_r = '0;
    sums   = 32'd1;
    csum_r = '0;
    type_r = '0;
  endfunction

  function automatic void expect_result(input lrd_pkg::res_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic void stream_add(input logic [7:0] b);
    stream_q = {stream_q, b};
  endfunction

  function automatic void push_report(input lrd_pkg::status_e st);
    lrd_pkg::res_t r;
    r               = '0;
    r.kind          = lrd_pkg::KindReport;
    r.status        = st;
    r.header_length = hlen_r;
    r.log_length    = llen_r;
    r.record_type   = type_r;
    r.checksum_read = csum_r;
    r.checksum_calc = sums;
    expect_result(r);
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    lrd_pkg::res_t r;
    logic [31:0]   w;
    r = '0;
    if (!halted) begin
      case (ph)
        lrd_pkg::PhHdr, lrd_pkg::PhLog: begin
          sums           = adler_next(sums, b);
          cnt            = cnt + 16'd1;
          r.kind         = (ph == lrd_pkg::PhHdr) ? lrd_pkg::KindHeader : lrd_pkg::KindLog;
          r.payload_byte = b;
          expect_result(r);
          if (cnt >= ((ph == lrd_pkg::PhHdr) ? hlen_r : llen_r)) begin
            cnt = '0;
            ph  = (ph == lrd_pkg::PhHdr) ? lrd_pkg::PhLlen : lrd_pkg::PhType;
          end
        end
        lrd_pkg::PhEnd: begin
          if (b != lrd_pkg::EndMark) begin
            halted = 1'b1;
            push_report(lrd_pkg::StBadEnd);
          end else begin
            push_report(lrd_pkg::StOk);
            clear_record();
          end
        end
        lrd_pkg::PhCsum, lrd_pkg::PhHlen, lrd_pkg::PhLlen, lrd_pkg::PhType: begin
          if (ph == lrd_pkg::PhType && cnt == 16'd0 && sums != csum_r) begin
            // check falls on the first type byte, which is swallowed
            halted = 1'b1;
            push_report(lrd_pkg::StMismatch);
          end else begin
            shreg = {b, shreg[31:8]};
            cnt   = cnt + 16'd1;
            if (cnt == 16'd4) begin
              cnt   = '0;
              w     = shreg;
              shreg = '0;
              case (ph)
                lrd_pkg::PhCsum: begin
                  csum_r = w;
                  ph     = lrd_pkg::PhHlen;
                end
                lrd_pkg::PhHlen: begin
                  hlen_r = w[15:0];
                  if (w > lrd_pkg::MaxFieldLen) begin
                    halted = 1'b1;
                    push_report(lrd_pkg::StRange);
                  end else begin
                    ph = (w == 32'd0) ? lrd_pkg::PhLlen : lrd_pkg::PhHdr;
                  end
                end
                lrd_pkg::PhLlen: begin
                  llen_r = w[15:0];
                  if (w > lrd_pkg::MaxFieldLen) begin
                    halted = 1'b1;
                    push_report(lrd_pkg::StRange);
                  end else begin
                    ph = (w == 32'd0) ? lrd_pkg::PhType : lrd_pkg::PhLog;
                  end
                end
                default: begin
                  type_r = w;
                  ph     = lrd_pkg::PhEnd;
                end
              endcase
            end
          end
        end
        default: begin
          ph  = lrd_pkg::PhCsum;
          cnt = '0;
        end
      endcase
    end
  endfunction

  function automatic void push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) begin
      stream_add(w[8*i +: 8]);
    end
  endfunction

  function automatic logic [7:0] fill_byte(input fill_e f);
    case (f)
      FillOnes:  return 8'hFF;
      FillZeros: return 8'h00;
      default:   return 8'($urandom);
    endcase
  endfunction

  // flawed records end the stream: the block stops on them until reset
  function automatic void add_record(input int hl, input int ll, input fill_e f,
                                     input logic [31:0] rtype, input flaw_e flaw);
    logic [7:0]  body[$];
    logic [31:0] acc;
    logic [31:0] bad_len;
    logic [7:0]  end_b;
    acc = 32'd1;
    for (int i = 0; i < hl + ll; i++) begin
      body = {body, fill_byte(f)};
      acc  = adler_next(acc, body[i]);
    end
    if (flaw == FlawSum) begin
      acc = acc ^ (32'd1 << $urandom_range(0, 31));
    end
    if ($urandom_range(0, 1) == 1) begin
      bad_len = {1'b1, 31'($urandom)};
    end else begin
      bad_len = 32'h0001_0000 | (32'($urandom) & 32'h00FF_FFFF);
    end
    end_b = lrd_pkg::EndMark;
    if (flaw == FlawEnd) begin
      while (end_b == lrd_pkg::EndMark) begin
        end_b = 8'($urandom);
      end
    end
    push_word(acc);
    push_word((flaw == FlawHlen) ? bad_len : 32'(hl));
    if (flaw != FlawHlen) begin
      for (int i = 0; i < hl; i++) begin
        stream_add(body[i]);
      end
      push_word((flaw == FlawLlen) ? bad_len : 32'(ll));
      if (flaw != FlawLlen) begin
        for (int i = hl; i < hl + ll; i++) begin
          stream_add(body[i]);
        end
        push_word(rtype);
        stream_add(end_b);
      end
    end
  endfunction

  function automatic int send_idle_pct();
    if (taken_n < total_n / 3) return 13;
    if (taken_n < 2 * total_n / 3) return 75;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (taken_n < total_n / 3) return 75;
    if (taken_n < 2 * total_n / 3) return 13;
    return 0;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_n++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    int    pick;
    int    hl;
    int    ll;
    fill_e f;
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    out_ch.ready     = 1'b0;
    halted           = 1'b0;
    clear_record();

    // empty sections, then single bytes, record type extremes
    add_record(0, 0, FillRandom, 32'h8000_0000, FlawNone);
    add_record(1, 1, FillOnes, 32'h7FFF_FFFF, FlawNone);

    while (stream_q.size() < 1580) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        // long runs push the high sum past the modulus, long runs of ones the low sum too
        hl = $urandom_range(150, 300);
        ll = $urandom_range(0, 150);
        f  = (pick == 0) ? FillOnes : FillRandom;
      end else if (pick < 20) begin
        hl = $urandom_range(0, 60);
        ll = $urandom_range(0, 60);
        f  = (pick < 5) ? FillZeros : FillRandom;
      end else begin
        hl = $urandom_range(0, 8);
        ll = $urandom_range(0, 12);
        f  = FillRandom;
      end
      add_record(hl, ll, f, 32'($urandom), FlawNone);
    end
    add_record($urandom_range(0, 6), $urandom_range(0, 6), FillRandom, 32'($urandom),
               flaw_e'($urandom_range(1, 4)));
    // trailing bytes must be swallowed
    for (int i = 0; i < 16; i++) begin
      stream_add(8'($urandom));
    end
    total_n = stream_q.size();

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    while (taken_n != total_n) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_n == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // byte driver: holds a word until taken
  always @(negedge clk_i) begin
    logic go;
    if (rst_ni && (!in_ch.valid || in_fire)) begin
      go = (stream_q.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct());
      if (go) begin
        in_ch.data_byte <= stream_q.pop_front();
      end
      in_ch.valid <= go;
    end
  end

  // result receiver; long hold-off at the start of the no-idle stretch
  always @(negedge clk_i) begin
    if (hold_left != 0 && total_n != 0 && taken_n >= 2 * total_n / 3) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct());
    end
  end

  always @(posedge clk_i) begin
    in_fire <= in_ch.valid && in_ch.ready;
    if (in_ch.valid && in_ch.ready) begin
      deframe_byte(in_ch.data_byte);
      taken_n <= taken_n + 1;
    end
  end

  always @(posedge clk_i) begin
    lrd_pkg::res_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with none expected: kind %0h", out_ch.kind);
        err_n++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_ch.kind));
        check_field("payload_byte", 32'(want.payload_byte), 32'(out_ch.payload_byte));
        check_field("status", 32'(want.status), 32'(out_ch.status));
        check_field("header_length", 32'(want.header_length), 32'(out_ch.header_length));
        check_field("log_length", 32'(want.log_length), 32'(out_ch.log_length));
        check_field("record_type", want.record_type, out_ch.record_type);
        check_field("checksum_read", want.checksum_read, out_ch.checksum_read);
        check_field("checksum_calc", want.checksum_calc, out_ch.checksum_calc);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_n <= 0;
    end else if (idle_n >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_n <= idle_n + 1;
    end
  end

endmodule

/* sim.f */
hw/rtl/lrd_pkg.sv
hw/rtl/lrd_if.sv
hw/rtl/lrd_core.sv
hw/rtl/lrd_out_fifo.sv
hw/rtl/log_record_deframer_adler32_unit.sv
test/log_record_deframer_adler32_unit_tb.sv
